FILE: rtl/core/bfms_pkg.sv
// Package for the bar-graph frame matrix scanner: widths, codes, FSM states
// and the thermometer-code helper. No dependencies.
`default_nettype none

package bfms_pkg;

  // Defaults for the top-level parameters
  localparam int ROWS_DEF    = 8;
  localparam int COLUMNS_DEF = 3;

  // Field and register widths
  localparam int BYTE_W     = 8;
  localparam int ROW_OUT_W  = 3;
  localparam int COL_OUT_W  = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int PAT_W      = 8;

  // Shared divider: numerator is (v-low)*7, quotient is a level step 0..7
  localparam int NUM_W = 11;
  localparam int DEN_W = 8;
  localparam int Q_W   = 3;

  localparam logic [BYTE_W-1:0] FRAME_END = 8'hFF;

  // Register index codes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIRST_LOW  = 2'd0,
    REG_FIRST_HIGH = 2'd1,
    REG_OTHER_LOW  = 2'd2,
    REG_OTHER_HIGH = 2'd3
  } cfg_reg_t;

  // Frame sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT
  } seq_state_t;

  // Thermometer code for level q+1: (2^(q+1))-1
  function automatic logic [PAT_W-1:0] therm_code(input logic [Q_W-1:0] q);
    logic [PAT_W:0] t;
    t = ((PAT_W+1)'(1) << (4'(q) + 4'd1)) - (PAT_W+1)'(1);
    return t[PAT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bfms_level_div.sv
// Shared restoring divider for the bar level: one quotient bit per cycle.
// Depends on bfms_pkg.
`default_nettype none

module bfms_level_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [bfms_pkg::NUM_W-1:0] num,
  input  wire logic [bfms_pkg::DEN_W-1:0] den,
  output logic                         done,
  output logic [bfms_pkg::Q_W-1:0]     quot
);
  import bfms_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [1:0]       step_r;
  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quot_r;
  logic [NUM_W-1:0] shifted;
  logic             fits;

  // Trial subtract of the divisor aligned to the current quotient bit
  always_comb begin
    shifted = NUM_W'(den_r) << step_r;
    fits    = (rem_r >= shifted);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (step_r == 2'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 2'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      step_r <= 2'(Q_W - 1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - shifted;
      end
      quot_r <= {quot_r[Q_W-2:0], fits};
      if (step_r != 2'd0) begin
        step_r <= step_r - 2'd1;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

FILE: rtl/core/bargraph_frame_matrix_scanner.sv
// A tick request gives its result in the output register in the cycle after acceptance;
// a data byte shifts into the window on acceptance. A frame-end byte (0xFF) keeps the
// block busy while, per column, the sequencer starts (ST_LOAD) and awaits (ST_WAIT) the
// shared 3-step divider. Otherwise one request per cycle while the result stream is not stalled.
// Reset (rst_n, synchronous) restores register defaults, clears window, bars and row.
// Top level: stream ports, config registers, frame sequencer; uses bfms_pkg, bfms_level_div.
`default_nettype none

module bargraph_frame_matrix_scanner #(
  parameter int ROWS    = bfms_pkg::ROWS_DEF,
  parameter int COLUMNS = bfms_pkg::COLUMNS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bfms_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] rx_data
  input  wire logic                           in_tuser,   // [0] func
  // Result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // [2:0] active_row, [5:3] column_bits
  // Configuration
  input  wire logic                           cfg_we,
  input  wire logic [bfms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bfms_pkg::BYTE_W-1:0]    cfg_wdata
);
  import bfms_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Configuration registers
  logic [BYTE_W-1:0] first_low_r, first_high_r, other_low_r, other_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_low_r  <= 8'd30;
      first_high_r <= 8'd97;
      other_low_r  <= 8'd0;
      other_high_r <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FIRST_LOW:  first_low_r  <= cfg_wdata;
        REG_FIRST_HIGH: first_high_r <= cfg_wdata;
        REG_OTHER_LOW:  other_low_r  <= cfg_wdata;
        REG_OTHER_HIGH: other_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State
  seq_state_t        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [BYTE_W-1:0] win_r [COLUMNS];
  logic [PAT_W-1:0]  pat_r [COLUMNS];
  logic [ROW_W-1:0]  row_r;
  logic              out_valid_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [COL_OUT_W-1:0] out_bits_r;

  // Handshake
  logic in_acc, is_tick, is_frame_end;
  assign in_tready    = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc       = in_tvalid && in_tready;
  assign is_tick      = in_tuser;
  assign is_frame_end = !is_tick && (in_tdata == FRAME_END);

  // Divider operand setup for the current column
  logic [BYTE_W-1:0] lo, hi, x, x_cl, diff;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_start, div_done;
  logic [Q_W-1:0]    div_quot;

  always_comb begin
    lo   = (col_r == '0) ? first_low_r  : other_low_r;
    hi   = (col_r == '0) ? first_high_r : other_high_r;
    x    = win_r[col_r];
    x_cl = (x < lo) ? lo : ((x > hi) ? hi : x);
    diff = x_cl - lo;
    if (hi <= lo) begin
      // Empty or inverted range: force quotient 7, i.e. full bar
      div_num = NUM_W'(7);
      div_den = DEN_W'(1);
    end else begin
      div_num = {diff, 3'b000} - NUM_W'(diff);
      div_den = hi - lo;
    end
  end

  assign div_start = (state_r == ST_LOAD);

  bfms_level_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Frame sequencer
  logic store_en, last_col;
  assign last_col = (col_r == COL_W'(COLUMNS - 1));

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    store_en  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_frame_end) begin
          state_nxt = ST_LOAD;
          col_nxt   = '0;
        end
      end
      ST_LOAD: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          store_en = 1'b1;
          if (last_col) begin
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + COL_W'(1);
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

  // Byte window: plain bytes shift in at once, frame end after the bars are done
  logic              shift_en;
  logic [BYTE_W-1:0] shift_byte;
  assign shift_en   = (in_acc && !is_tick && !is_frame_end) || (store_en && last_col);
  assign shift_byte = (state_r == ST_IDLE) ? in_tdata : FRAME_END;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) begin
        win_r[c] <= '0;
      end
    end else if (shift_en) begin
      for (int c = 0; c < COLUMNS - 1; c++) begin
        win_r[c] <= win_r[c+1];
      end
      win_r[COLUMNS-1] <= shift_byte;
    end
  end

  // Bar patterns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) begin
        pat_r[c] <= '0;
      end
    end else if (store_en) begin
      pat_r[col_r] <= therm_code(div_quot);
    end
  end

  // Row scan on tick
  logic [ROW_W-1:0]     row_nxt;
  logic [2:0]           row_bit;
  logic                 row_lit;
  logic [COL_OUT_W-1:0] bits_nxt;

  assign row_nxt = (row_r == ROW_W'(ROWS - 1)) ? '0 : row_r + ROW_W'(1);
  assign row_bit = 3'(row_nxt);
  assign row_lit = (5'(row_nxt) < 5'd8);

  for (genvar g = 0; g < COL_OUT_W; g++) begin : g_bits
    if (g < COLUMNS) begin : g_col
      assign bits_nxt[g] = row_lit && pat_r[g][row_bit];
    end else begin : g_none
      assign bits_nxt[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && is_tick) begin
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_tick) begin
      out_row_r  <= ROW_OUT_W'(row_nxt);
      out_bits_r <= bits_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_bits_r, out_row_r};

endmodule

`default_nettype wire
